// ===== rtl/kcwf_pkg.sv =====
package kcwf_pkg;

    localparam int LED_COLUMNS = 24;
    localparam int KEY_ROWS    = 8;
    localparam int KEY_COLUMNS = 32;

    localparam int COL_W    = $clog2(LED_COLUMNS);
    localparam int CNT_W    = $clog2(LED_COLUMNS + 1);
    localparam int KD_DEPTH = KEY_ROWS * KEY_COLUMNS;
    localparam int KD_W     = (KD_DEPTH > 1) ? $clog2(KD_DEPTH) : 1;

    // results of one new press: previous, sweep and next column
    localparam int PRESS_RESULTS = 3;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY_CHK,
        S_RUN
    } t_state;

    typedef enum logic {
        CMD_KEY  = 1'b0,
        CMD_TICK = 1'b1
    } t_command;

    typedef struct packed {
        logic       command;
        logic [2:0] key_row;
        logic [4:0] key_col;
        logic       pressed;
        logic [6:0] rand_red;
        logic [6:0] rand_green;
        logic [6:0] rand_blue;
    } t_in_item;

    typedef struct packed {
        logic [5:0] led_column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic             capture;
        logic             kd_write;
        logic             rd_issue;
        logic             adv;
        logic             tick;
        logic             out_last;
        logic             sweep_adv;
        logic [CNT_W-1:0] iss_idx;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_tick;
        logic in_range;
        logic new_press;
        logic out_free;
    } t_dp_status;

    // floor(c * 99 / 100) equals c - ceil(c / 100)
    function automatic logic [7:0] decay(input logic [7:0] c);
        logic [1:0] d;
        if (c == 8'd0) begin
            d = 2'd0;
        end else if (c <= 8'd100) begin
            d = 2'd1;
        end else if (c <= 8'd200) begin
            d = 2'd2;
        end else begin
            d = 2'd3;
        end
        return c - {6'd0, d};
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [6:0] b);
        logic [8:0] s;
        s = {1'b0, c} + {2'b00, b};
        return s[8] ? CHAN_MAX : s[7:0];
    endfunction

endpackage

// ===== rtl/kcwf_if.sv =====
interface kcwf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [2:0] key_row;
    logic [4:0] key_col;
    logic       pressed;
    logic [6:0] rand_red;
    logic [6:0] rand_green;
    logic [6:0] rand_blue;

    modport source(output valid, command, key_row, key_col, pressed,
                   rand_red, rand_green, rand_blue, input ready);
    modport sink(input valid, command, key_row, key_col, pressed,
                 rand_red, rand_green, rand_blue, output ready);
endinterface

interface kcwf_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source(output valid, led_column, red, green, blue, last, input ready);
    modport sink(input valid, led_column, red, green, blue, last, output ready);
endinterface

// ===== rtl/kcwf_ctrl.sv =====
module kcwf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  kcwf_pkg::t_dp_status i_status,
    output kcwf_pkg::t_ctl_cmd   o_cmd
);

    kcwf_pkg::t_state               r_state, n_state;
    logic                           r_tick, n_tick;
    logic                           r_pend, n_pend;
    logic [kcwf_pkg::CNT_W-1:0]     r_iss, n_iss;
    logic [kcwf_pkg::CNT_W-1:0]     total;
    logic                           adv;
    logic                           issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcwf_pkg::S_IDLE;
            r_tick  <= 1'b0;
            r_pend  <= 1'b0;
            r_iss   <= '0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_pend  <= n_pend;
            r_iss   <= n_iss;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_pend     = r_pend;
        n_iss      = r_iss;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        total      = r_tick ? kcwf_pkg::CNT_W'(kcwf_pkg::LED_COLUMNS)
                            : kcwf_pkg::CNT_W'(kcwf_pkg::PRESS_RESULTS);
        adv        = 1'b0;
        issue      = 1'b0;
        case (r_state)
            kcwf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_tick) begin
                        n_tick  = 1'b1;
                        n_iss   = '0;
                        n_pend  = 1'b0;
                        n_state = kcwf_pkg::S_RUN;
                    end else if (i_status.in_range) begin
                        n_state = kcwf_pkg::S_KEY_CHK;
                    end
                end
            end
            kcwf_pkg::S_KEY_CHK: begin
                o_cmd.kd_write = 1'b1;
                if (i_status.new_press) begin
                    n_tick  = 1'b0;
                    n_iss   = '0;
                    n_pend  = 1'b0;
                    n_state = kcwf_pkg::S_RUN;
                end else begin
                    n_state = kcwf_pkg::S_IDLE;
                end
            end
            kcwf_pkg::S_RUN: begin
                // read one column ahead while the previous one is written back
                adv   = r_pend && i_status.out_free;
                issue = (r_iss != total) && (!r_pend || adv);
                o_cmd.adv      = adv;
                o_cmd.rd_issue = issue;
                o_cmd.tick     = r_tick;
                o_cmd.iss_idx  = r_iss;
                o_cmd.out_last = (r_iss == total);
                if (issue) begin
                    n_iss  = r_iss + 1'b1;
                    n_pend = 1'b1;
                end else if (adv) begin
                    n_pend = 1'b0;
                end
                if (adv && (r_iss == total)) begin
                    o_cmd.sweep_adv = !r_tick;
                    n_state         = kcwf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kcwf_pkg::S_IDLE;
            end
        endcase
    end

    a_iss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kcwf_pkg::S_RUN) |-> (r_iss <= total))
        else $error("issue count beyond item length");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kcwf_pkg::S_IDLE) |-> !r_pend)
        else $error("read still pending in idle");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kcwf_pkg::S_RUN) && adv && (r_iss == total))
        |=> (r_state == kcwf_pkg::S_IDLE))
        else $error("no return to idle after final transfer");

endmodule

// ===== rtl/kcwf_dp.sv =====
module kcwf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kcwf_pkg::t_ctl_cmd   i_cmd,
    input  kcwf_pkg::t_in_item   i_item,
    input  logic                 i_out_ready,
    output kcwf_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output kcwf_pkg::t_out_item  o_out
);

    // key pressed map
    logic                           r_kd_mem [kcwf_pkg::KD_DEPTH];
    logic [kcwf_pkg::KD_DEPTH-1:0]  r_kd_vld;
    logic [kcwf_pkg::KD_W-1:0]      kd_idx;
    logic [kcwf_pkg::KD_W-1:0]      r_kd_idx;
    logic                           r_kd_raw;
    logic                           r_kd_rvld;
    logic                           r_pressed;
    logic [6:0]                     r_boost_r, r_boost_g, r_boost_b;

    // column colors
    logic [23:0]                       r_col_mem [kcwf_pkg::LED_COLUMNS];
    logic [kcwf_pkg::LED_COLUMNS-1:0]  r_col_vld;
    logic [23:0]                       r_rd_raw;
    logic                              r_rd_vld;
    logic [kcwf_pkg::COL_W-1:0]        r_wr_col;
    logic [kcwf_pkg::COL_W-1:0]        rd_addr;
    logic [kcwf_pkg::COL_W-1:0]        r_sweep;
    logic [kcwf_pkg::COL_W-1:0]        sweep_prev, sweep_next;
    logic [23:0]                       old_color, new_color;

    logic                              r_out_vld;
    kcwf_pkg::t_out_item               r_out;

    assign kd_idx = kcwf_pkg::KD_W'(int'(i_item.key_row) * kcwf_pkg::KEY_COLUMNS
                                    + int'(i_item.key_col));

    assign sweep_prev = (r_sweep == '0) ? kcwf_pkg::COL_W'(kcwf_pkg::LED_COLUMNS - 1)
                                        : r_sweep - 1'b1;
    assign sweep_next = (r_sweep == kcwf_pkg::COL_W'(kcwf_pkg::LED_COLUMNS - 1))
                        ? '0 : r_sweep + 1'b1;

    always_comb begin
        if (i_cmd.tick) begin
            rd_addr = i_cmd.iss_idx[kcwf_pkg::COL_W-1:0];
        end else begin
            case (i_cmd.iss_idx[1:0])
                2'd0:    rd_addr = sweep_prev;
                2'd1:    rd_addr = r_sweep;
                default: rd_addr = sweep_next;
            endcase
        end
    end

    assign old_color = r_rd_vld ? r_rd_raw : '0;

    always_comb begin
        if (i_cmd.tick) begin
            new_color = {kcwf_pkg::decay(old_color[23:16]),
                         kcwf_pkg::decay(old_color[15:8]),
                         kcwf_pkg::decay(old_color[7:0])};
        end else begin
            new_color = {kcwf_pkg::sat_add(old_color[23:16], r_boost_r),
                         kcwf_pkg::sat_add(old_color[15:8], r_boost_g),
                         kcwf_pkg::sat_add(old_color[7:0], r_boost_b)};
        end
    end

    // key map: read at capture, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kd_raw  <= r_kd_mem[kd_idx];
            r_kd_rvld <= r_kd_vld[kd_idx];
            r_kd_idx  <= kd_idx;
            r_pressed <= i_item.pressed;
            r_boost_r <= i_item.rand_red;
            r_boost_g <= i_item.rand_green;
            r_boost_b <= i_item.rand_blue;
        end
        if (i_cmd.kd_write) begin
            r_kd_mem[r_kd_idx] <= r_pressed;
        end
    end

    // color memory: registered read, write-back of the previous column
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_raw <= r_col_mem[rd_addr];
            r_rd_vld <= r_col_vld[rd_addr];
            r_wr_col <= rd_addr;
        end
        if (i_cmd.adv) begin
            r_col_mem[r_wr_col] <= new_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kd_vld  <= '0;
            r_col_vld <= '0;
            r_sweep   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.kd_write) begin
                r_kd_vld[r_kd_idx] <= 1'b1;
            end
            if (i_cmd.adv) begin
                r_col_vld[r_wr_col] <= 1'b1;
            end
            if (i_cmd.sweep_adv) begin
                r_sweep <= sweep_next;
            end
            if (i_cmd.adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            r_out.led_column <= 6'(r_wr_col);
            r_out.red        <= new_color[23:16];
            r_out.green      <= new_color[15:8];
            r_out.blue       <= new_color[7:0];
            r_out.last       <= i_cmd.out_last;
        end
    end

    assign o_status.in_tick   = (i_item.command == kcwf_pkg::CMD_TICK);
    assign o_status.in_range  = (int'(i_item.key_row) < kcwf_pkg::KEY_ROWS)
                             && (int'(i_item.key_col) < kcwf_pkg::KEY_COLUMNS);
    assign o_status.new_press = !(r_kd_rvld && r_kd_raw) && r_pressed;
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_adv_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv |-> (!r_out_vld || i_out_ready))
        else $error("result overwrites an untaken result");

    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sweep) < kcwf_pkg::LED_COLUMNS)
        else $error("sweep pointer out of range");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.adv && i_cmd.rd_issue) |-> (rd_addr != r_wr_col))
        else $error("read of the column being written back");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv |-> (int'(r_wr_col) < kcwf_pkg::LED_COLUMNS))
        else $error("color write beyond last column");

endmodule

// ===== rtl/keypress_color_wipe_fader_top.sv =====
// a new key press is checked in the key map, then its three columns (previous,
//   sweep, next) are read and written back, one column per cycle while the
//   receiver takes each result, and a tick does the same for all LED_COLUMNS
//   columns; an input item is taken only in idle, after the last one is done
// reset: synchronous, active low; all colors black, no key pressed, sweep at column 0
module keypress_color_wipe_fader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kcwf_in_if.sink     i_in,
    kcwf_out_if.source  o_out
);

    // command and status between the sequencer and the datapath
    kcwf_pkg::t_ctl_cmd   cmd;
    kcwf_pkg::t_dp_status status;
    kcwf_pkg::t_in_item   in_item;
    kcwf_pkg::t_out_item  out_item;
    logic                 out_valid;
    logic                 in_ready;

    // input payload gathered into one bundle
    assign in_item.command    = i_in.command;
    assign in_item.key_row    = i_in.key_row;
    assign in_item.key_col    = i_in.key_col;
    assign in_item.pressed    = i_in.pressed;
    assign in_item.rand_red   = i_in.rand_red;
    assign in_item.rand_green = i_in.rand_green;
    assign in_item.rand_blue  = i_in.rand_blue;
    assign i_in.ready         = in_ready;

    // sequencer: accepts an item, reads the key map, walks the columns
    kcwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: key map, color memory, sweep pointer and output register
    kcwf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (in_item),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_out       (out_item)
    );

    // result transfer
    assign o_out.valid      = out_valid;
    assign o_out.led_column = out_item.led_column;
    assign o_out.red        = out_item.red;
    assign o_out.green      = out_item.green;
    assign o_out.blue       = out_item.blue;
    assign o_out.last       = out_item.last;

endmodule

// ===== tb/sv/keypress_color_wipe_fader_top_tb.sv =====
`timescale 1ns / 1ps

module keypress_color_wipe_fader_top_tb;

    localparam int RANDOM_ITEMS   = 445;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOT_KEYS       = 6;

    // one directed row: the item, and where the outcome is obvious, the colors
    // that every result of it must carry, starting at first_col and wrapping
    typedef struct packed {
        kcwf_pkg::t_in_item item;
        logic               fixed_exp;
        logic [5:0]         n_fixed;
        logic [5:0]         first_col;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_stim_row;

    localparam int DIRECTED_COUNT = 15;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // tick on an all-black strip: every column stays black
        '{'{kcwf_pkg::CMD_TICK, 3'd0, 5'd0, 1'b0, 7'd0, 7'd0, 7'd0}, 1'b1, 6'd24, 6'd0,
          8'd0, 8'd0, 8'd0},
        // first press lands on sweep 0 and its wrapped neighbors 23 and 1;
        // blue boost above 119 is added as given
        '{'{kcwf_pkg::CMD_KEY, 3'd0, 5'd0, 1'b1, 7'd119, 7'd0, 7'd127}, 1'b1, 6'd3, 6'd23,
          8'd119, 8'd0, 8'd127},
        // same key pressed again while held: no color change, no transfer
        '{'{kcwf_pkg::CMD_KEY, 3'd0, 5'd0, 1'b1, 7'd119, 7'd0, 7'd127}, 1'b1, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // release ignores the boosts
        '{'{kcwf_pkg::CMD_KEY, 3'd0, 5'd0, 1'b0, 7'd127, 7'd127, 7'd127}, 1'b1, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // far corner of the key matrix, zero boost still reports three columns
        '{'{kcwf_pkg::CMD_KEY, 3'd7, 5'd31, 1'b1, 7'd0, 7'd0, 7'd0}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_KEY, 3'd7, 5'd31, 1'b1, 7'd119, 7'd119, 7'd119}, 1'b1, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // stacked max boosts drive channels into saturation
        '{'{kcwf_pkg::CMD_KEY, 3'd3, 5'd16, 1'b1, 7'd127, 7'd127, 7'd127}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_KEY, 3'd4, 5'd15, 1'b1, 7'd127, 7'd127, 7'd127}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_KEY, 3'd2, 5'd10, 1'b1, 7'd119, 7'd119, 7'd119}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_KEY, 3'd5, 5'd21, 1'b1, 7'd127, 7'd0, 7'd64}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // tick with junk in the key fields, decays saturated channels
        '{'{kcwf_pkg::CMD_TICK, 3'd7, 5'd31, 1'b1, 7'd127, 7'd127, 7'd127}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // a released key pressed again is a new press
        '{'{kcwf_pkg::CMD_KEY, 3'd0, 5'd0, 1'b1, 7'd1, 7'd2, 7'd3}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        // release of a key that was never down
        '{'{kcwf_pkg::CMD_KEY, 3'd6, 5'd5, 1'b0, 7'd127, 7'd127, 7'd127}, 1'b1, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_TICK, 3'd0, 5'd0, 1'b0, 7'd0, 7'd0, 7'd0}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0},
        '{'{kcwf_pkg::CMD_KEY, 3'd1, 5'd26, 1'b1, 7'd60, 7'd90, 7'd30}, 1'b0, 6'd0, 6'd0,
          8'd0, 8'd0, 8'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    kcwf_in_if  key_bus();
    kcwf_out_if led_bus();

    keypress_color_wipe_fader_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_bus),
        .o_out   (led_bus)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the lighting state, updated at each accepted input transfer
    logic [7:0]  red_lvl [kcwf_pkg::LED_COLUMNS];
    logic [7:0]  grn_lvl [kcwf_pkg::LED_COLUMNS];
    logic [7:0]  blu_lvl [kcwf_pkg::LED_COLUMNS];
    bit          key_down [kcwf_pkg::KEY_ROWS * kcwf_pkg::KEY_COLUMNS];
    int unsigned sweep_col;

    kcwf_pkg::t_out_item fresh_updates [$];   // column updates of the item just accepted
    kcwf_pkg::t_out_item pending_colors [$];  // column updates not yet seen on the output

    // fixed expectation of the item currently on the input bus
    logic       cur_fixed;
    logic [5:0] cur_n_fixed;
    logic [5:0] cur_first_col;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;

    bit no_idle;
    int err_count;
    int key_count;
    int tick_count;
    int press_count;
    int update_count;
    int idle_cycles;

    function automatic logic [7:0] boost_channel(input logic [7:0] c, input logic [6:0] b);
        int s;
        s = int'(c) + int'(b);
        return (s > 255) ? 8'd255 : 8'(s);
    endfunction

    function automatic logic [7:0] fade_channel(input logic [7:0] c);
        return 8'((int'(c) * 99) / 100);
    endfunction

    function automatic void stage_update(input int unsigned col, input bit is_last);
        kcwf_pkg::t_out_item u;
        u.led_column = 6'(col);
        u.red        = red_lvl[col];
        u.green      = grn_lvl[col];
        u.blue       = blu_lvl[col];
        u.last       = is_last;
        fresh_updates.push_back(u);
    endfunction

    // advance the shadow state by one input item, staging its column updates
    function automatic void predict_lighting(input kcwf_pkg::t_in_item it);
        int unsigned kidx;
        int unsigned cols [3];
        logic [7:0]  nr [3];
        logic [7:0]  ng [3];
        logic [7:0]  nb [3];
        if (it.command == kcwf_pkg::CMD_TICK) begin
            for (int c = 0; c < kcwf_pkg::LED_COLUMNS; c++) begin
                red_lvl[c] = fade_channel(red_lvl[c]);
                grn_lvl[c] = fade_channel(grn_lvl[c]);
                blu_lvl[c] = fade_channel(blu_lvl[c]);
                stage_update(c, c == kcwf_pkg::LED_COLUMNS - 1);
            end
            return;
        end
        if (int'(it.key_row) >= kcwf_pkg::KEY_ROWS ||
            int'(it.key_col) >= kcwf_pkg::KEY_COLUMNS) return;
        kidx = it.key_row * kcwf_pkg::KEY_COLUMNS + it.key_col;
        if (!key_down[kidx] && it.pressed) begin
            cols[0] = (sweep_col + kcwf_pkg::LED_COLUMNS - 1) % kcwf_pkg::LED_COLUMNS;
            cols[1] = sweep_col;
            cols[2] = (sweep_col + 1) % kcwf_pkg::LED_COLUMNS;
            // all three sums from the old colors
            for (int k = 0; k < 3; k++) begin
                nr[k] = boost_channel(red_lvl[cols[k]], it.rand_red);
                ng[k] = boost_channel(grn_lvl[cols[k]], it.rand_green);
                nb[k] = boost_channel(blu_lvl[cols[k]], it.rand_blue);
            end
            for (int k = 0; k < 3; k++) begin
                red_lvl[cols[k]] = nr[k];
                grn_lvl[cols[k]] = ng[k];
                blu_lvl[cols[k]] = nb[k];
                stage_update(cols[k], k == 2);
            end
            sweep_col = (sweep_col + 1 >= kcwf_pkg::LED_COLUMNS) ? 0 : sweep_col + 1;
            press_count++;
        end
        key_down[kidx] = it.pressed;
    endfunction

    function automatic kcwf_pkg::t_in_item random_key_item(input int tick_pct);
        kcwf_pkg::t_in_item it;
        int unsigned        hot;
        it.command = ($urandom_range(99) < tick_pct) ? kcwf_pkg::CMD_TICK : kcwf_pkg::CMD_KEY;
        if ($urandom_range(1) == 0) begin
            // small pool of keys so presses and releases pair up
            hot        = $urandom_range(HOT_KEYS - 1);
            it.key_row = 3'(hot);
            it.key_col = 5'(hot * 5);
            if ($urandom_range(99) < 85)
                it.pressed = ~key_down[it.key_row * kcwf_pkg::KEY_COLUMNS + it.key_col];
            else
                it.pressed = 1'($urandom_range(1));
        end else begin
            it.key_row = 3'($urandom_range(kcwf_pkg::KEY_ROWS - 1));
            it.key_col = 5'($urandom_range(kcwf_pkg::KEY_COLUMNS - 1));
            it.pressed = 1'($urandom_range(1));
        end
        // mostly the nominal 0..119 range, sometimes the full field
        it.rand_red   = 7'(($urandom_range(99) < 85) ? $urandom_range(119) : $urandom_range(127));
        it.rand_green = 7'(($urandom_range(99) < 85) ? $urandom_range(119) : $urandom_range(127));
        it.rand_blue  = 7'(($urandom_range(99) < 85) ? $urandom_range(119) : $urandom_range(127));
        return it;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // drive one item from the falling edge, idling at random first,
    // and return once its transfer has happened
    task automatic send_item(input kcwf_pkg::t_in_item it, input logic fixed,
                             input logic [5:0] n_fixed,
                             input logic [5:0] first_col, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 14) begin
            key_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        key_bus.valid      = 1'b1;
        key_bus.command    = it.command;
        key_bus.key_row    = it.key_row;
        key_bus.key_col    = it.key_col;
        key_bus.pressed    = it.pressed;
        key_bus.rand_red   = it.rand_red;
        key_bus.rand_green = it.rand_green;
        key_bus.rand_blue  = it.rand_blue;
        cur_fixed          = fixed;
        cur_n_fixed        = n_fixed;
        cur_first_col      = first_col;
        cur_red            = r;
        cur_green          = g;
        cur_blue           = b;
        do @(posedge i_clk); while (key_bus.ready !== 1'b1);
    endtask

    // receiver stalls at random except in the no-idle stretch
    always @(negedge i_clk) begin
        led_bus.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 14);
    end

    // scoreboard: output transfer checked first, then the input transfer
    // of the same edge is predicted
    always @(posedge i_clk) begin
        kcwf_pkg::t_out_item want;
        kcwf_pkg::t_in_item  acc;
        if (led_bus.valid === 1'b1 && led_bus.ready) begin
            update_count++;
            if (pending_colors.size() == 0) begin
                $error("led_column %0d: transfer with no expected update waiting",
                       led_bus.led_column);
                err_count++;
            end else begin
                want = pending_colors.pop_front();
                check_field("led_column", 8'(want.led_column), 8'(led_bus.led_column));
                check_field("red", want.red, led_bus.red);
                check_field("green", want.green, led_bus.green);
                check_field("blue", want.blue, led_bus.blue);
                check_field("last", 8'(want.last), 8'(led_bus.last));
            end
        end
        if (key_bus.valid === 1'b1 && key_bus.ready === 1'b1) begin
            acc.command    = key_bus.command;
            acc.key_row    = key_bus.key_row;
            acc.key_col    = key_bus.key_col;
            acc.pressed    = key_bus.pressed;
            acc.rand_red   = key_bus.rand_red;
            acc.rand_green = key_bus.rand_green;
            acc.rand_blue  = key_bus.rand_blue;
            if (acc.command == kcwf_pkg::CMD_TICK) tick_count++;
            else key_count++;
            fresh_updates.delete();
            predict_lighting(acc);
            if (cur_fixed) begin
                // directed row with the colors typed in the table
                for (int k = 0; k < cur_n_fixed; k++) begin
                    want.led_column = 6'((cur_first_col + k) % kcwf_pkg::LED_COLUMNS);
                    want.red        = cur_red;
                    want.green      = cur_green;
                    want.blue       = cur_blue;
                    want.last       = (k == cur_n_fixed - 1);
                    pending_colors.push_back(want);
                end
            end else begin
                foreach (fresh_updates[k]) pending_colors.push_back(fresh_updates[k]);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((key_bus.valid === 1'b1 && key_bus.ready === 1'b1) ||
            (led_bus.valid === 1'b1 && led_bus.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stalled for %0d cycles with %0d updates outstanding",
                     idle_cycles, pending_colors.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int tick_pct;
        i_rst_n            = 1'b0;
        key_bus.valid      = 1'b0;
        key_bus.command    = kcwf_pkg::CMD_KEY;
        key_bus.key_row    = '0;
        key_bus.key_col    = '0;
        key_bus.pressed    = 1'b0;
        key_bus.rand_red   = '0;
        key_bus.rand_green = '0;
        key_bus.rand_blue  = '0;
        led_bus.ready      = 1'b0;
        cur_fixed          = 1'b0;
        cur_n_fixed        = '0;
        cur_first_col      = '0;
        cur_red            = '0;
        cur_green          = '0;
        cur_blue           = '0;
        no_idle            = 1'b0;
        err_count          = 0;
        key_count          = 0;
        tick_count         = 0;
        press_count        = 0;
        update_count       = 0;
        idle_cycles        = 0;
        sweep_col          = 0;
        for (int c = 0; c < kcwf_pkg::LED_COLUMNS; c++) begin
            red_lvl[c] = '0;
            grn_lvl[c] = '0;
            blu_lvl[c] = '0;
        end
        foreach (key_down[k]) key_down[k] = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].fixed_exp,
                      DIRECTED_ROWS[i].n_fixed, DIRECTED_ROWS[i].first_col,
                      DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].blue);
        end

        // random traffic: mostly key events, a tick-heavy stretch to walk the
        // colors down through the decay steps, a stretch with no stalls on
        // either side, and two points where the sender waits for a drained strip
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200 || n == 380) begin
                @(negedge i_clk);
                key_bus.valid = 1'b0;
                while (pending_colors.size() != 0) @(posedge i_clk);
            end
            no_idle  = (n >= 300 && n < 380);
            tick_pct = (n >= 200 && n < 290) ? 70 : 8;
            send_item(random_key_item(tick_pct), 1'b0, '0, '0, '0, '0, '0);
        end

        @(negedge i_clk);
        key_bus.valid = 1'b0;
        no_idle       = 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_colors.size() != 0) begin
            $error("%0d expected column updates never arrived", pending_colors.size());
            err_count++;
        end

        $display("run covered %0d key events (%0d new presses) and %0d decay ticks",
                 key_count, press_count, tick_count);
        $display("%0d column updates compared, %0d mismatches", update_count, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
